// ----- hw/rtl/trl_pkg.sv -----
package trl_pkg;

  localparam int RPM_W     = 11;
  localparam int CAP_W     = 8;
  localparam int TENTHS_W  = 12;
  localparam int HELD_W    = 13;
  localparam int NUM_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam logic [TENTHS_W-1:0] MAX_TENTHS  = 12'd2550;
  localparam logic [9:0]          ELAPSED_MAX = 10'd1023;
  localparam logic [12:0]         DIV10_MUL   = 13'd6554;

  localparam logic [9:0] RST_INTERVAL    = 10'd30;
  localparam logic [6:0] RST_RAMP_STEP   = 7'd2;
  localparam logic [6:0] RST_START_OFF   = 7'd20;
  localparam logic [7:0] RST_FULL_LEVEL  = 8'd95;
  localparam logic [7:0] RST_BASE_CAP    = 8'd80;
  localparam logic [7:0] RST_CAP_CEILING = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPDATE_INTERVAL = 3'd0,
    REG_RAMP_STEP       = 3'd1,
    REG_START_OFFSET    = 3'd2,
    REG_FULL_LEVEL      = 3'd3,
    REG_BASE_CAP        = 3'd4,
    REG_CAP_CEILING     = 3'd5
  } trl_reg_t;

  typedef struct packed {
    logic [9:0] update_interval_ms;
    logic [6:0] ramp_step_tenths;
    logic [6:0] start_offset;
    logic [7:0] full_throttle_level;
    logic [7:0] base_cap;
    logic [7:0] cap_ceiling;
  } trl_cfg_t;

  // Tick that fires an update, as it enters the cap pipeline.
  typedef struct packed {
    logic [7:0]       request;
    logic             kill;
    logic [RPM_W-1:0] rpm;
    logic [6:0]       comp;
  } trl_item_t;

  // Update request after the rpm cap has been resolved.
  typedef struct packed {
    logic [7:0]       request;
    logic             kill;
    logic [7:0]       rpm_div10;
    logic [CAP_W-1:0] cap;
  } trl_capped_t;

  // Divide by ten through a reciprocal; exact for x up to 2550.
  function automatic logic [7:0] div10(input logic [11:0] x);
    logic [24:0] p;
    p = {13'b0, x} * {12'b0, DIV10_MUL};
    return p[23:16];
  endfunction

endpackage

// ----- hw/rtl/trl_cfg_regs.sv -----
module trl_cfg_regs
  import trl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wr_data,
  output trl_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.update_interval_ms  <= RST_INTERVAL;
      cfg.ramp_step_tenths    <= RST_RAMP_STEP;
      cfg.start_offset        <= RST_START_OFF;
      cfg.full_throttle_level <= RST_FULL_LEVEL;
      cfg.base_cap            <= RST_BASE_CAP;
      cfg.cap_ceiling         <= RST_CAP_CEILING;
    end else if (cfg_wr_en) begin
      unique case (trl_reg_t'(cfg_index))
        REG_UPDATE_INTERVAL: cfg.update_interval_ms  <= cfg_wr_data;
        REG_RAMP_STEP:       cfg.ramp_step_tenths    <= cfg_wr_data[6:0];
        REG_START_OFFSET:    cfg.start_offset        <= cfg_wr_data[6:0];
        REG_FULL_LEVEL:      cfg.full_throttle_level <= cfg_wr_data[7:0];
        REG_BASE_CAP:        cfg.base_cap            <= cfg_wr_data[7:0];
        REG_CAP_CEILING:     cfg.cap_ceiling         <= cfg_wr_data[7:0];
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

endmodule

// ----- hw/rtl/trl_cap_calc.sv -----
module trl_cap_calc
  import trl_pkg::*;
#(
  parameter int RELEASE_RPM = 500
) (
  input  logic        clk,
  input  logic        rst,
  input  trl_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  trl_item_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output trl_capped_t out_item
);

  localparam logic [RPM_W-1:0] RELEASE = RPM_W'(RELEASE_RPM);

  // A positive interpolation numerator stays below 256 * RELEASE_RPM, so a
  // rounded-up reciprocal gives the exact truncated quotient.
  localparam int RPM_LOG = $clog2(RELEASE_RPM);
  localparam int QNUM_W  = CAP_W + RPM_LOG;
  localparam int DIV_SH  = QNUM_W + RPM_LOG;
  localparam int RECIP_W = QNUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(RELEASE_RPM) - 64'd1) / 64'(RELEASE_RPM));

  logic      s1_valid, s2_valid, s3_valid;
  logic      s1_ready, s2_ready, s3_ready;
  trl_item_t s1;

  logic [7:0]              s2_request;
  logic                    s2_kill;
  logic [7:0]              s2_div10;
  logic signed [9:0]       s2_top;
  logic signed [NUM_W-1:0] s2_prod;
  logic                    s2_low_rpm;

  trl_capped_t s3;

  logic signed [9:0]          top_raw, top, diff;
  logic signed [NUM_W-1:0]    prod;
  logic signed [NUM_W-1:0]    num;
  logic [QNUM_W+RECIP_W-1:0]  qprod;
  logic [CAP_W-1:0]           quo, cap;

  assign s3_ready = !s3_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1 -> 2: compensated cap top and the rpm-weighted slope term.
  always_comb begin
    top_raw = $signed({2'b00, cfg.base_cap}) + $signed({{3{s1.comp[6]}}, s1.comp});
    top     = (top_raw > $signed({2'b00, cfg.cap_ceiling})) ?
              $signed({2'b00, cfg.cap_ceiling}) : top_raw;
    diff    = top - $signed({3'b000, cfg.start_offset});
    prod    = NUM_W'(diff) * $signed(NUM_W'({1'b0, s1.rpm}));
  end

  // Stage 2 -> 3: interpolate the cap, divide through the reciprocal.
  always_comb begin
    num   = $signed(NUM_W'(cfg.start_offset) * NUM_W'(RELEASE)) + s2_prod;
    qprod = {{RECIP_W{1'b0}}, num[QNUM_W-1:0]} * {{QNUM_W{1'b0}}, RECIP};
    quo   = qprod[DIV_SH +: CAP_W];
    if (s2_low_rpm) begin
      cap = (num <= 0) ? '0 : quo;
    end else begin
      cap = (s2_top < 0) ? '0 : s2_top[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1 <= in_item;
    if (s2_ready && s1_valid) begin
      s2_request <= s1.request;
      s2_kill    <= s1.kill;
      s2_div10   <= div10({1'b0, s1.rpm});
      s2_top     <= top;
      s2_prod    <= prod;
      s2_low_rpm <= (s1.rpm <= RELEASE);
    end
    if (s3_ready && s2_valid) begin
      s3.request   <= s2_request;
      s3.kill      <= s2_kill;
      s3.rpm_div10 <= s2_div10;
      s3.cap       <= cap;
    end
  end

  assign out_valid = s3_valid;
  assign out_item  = s3;

endmodule

// ----- hw/rtl/trl_ramp.sv -----
module trl_ramp
  import trl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  trl_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  trl_capped_t in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pot_value
);

  logic [TENTHS_W-1:0] throttle_tenths, throttle_tenths_next;
  logic                load;
  logic [7:0]          req;
  logic [8:0]          floor_sum;
  logic [HELD_W-1:0]   floor_t, req10, cap10, held0, held1, held2, held3, held4;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    req       = in_item.kill ? 8'd0 : in_item.request;
    held0     = in_item.kill ? '0 : {1'b0, throttle_tenths};
    floor_sum = {2'b00, cfg.start_offset} + {1'b0, in_item.rpm_div10};
    floor_t   = {1'b0, floor_sum, 3'b000} + {3'b000, floor_sum, 1'b0};
    req10     = {2'b00, req, 3'b000} + {4'b0000, req, 1'b0};
    cap10     = {2'b00, in_item.cap, 3'b000} + {4'b0000, in_item.cap, 1'b0};
    held1     = (held0 < floor_t) ? floor_t : held0;
    held2     = held1 + {6'b0, cfg.ramp_step_tenths};
    held3     = (held2 > req10) ? req10 : held2;
    held4     = ((req < cfg.full_throttle_level) && (held3 > cap10)) ? cap10 : held3;
    throttle_tenths_next = held4[TENTHS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_tenths <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (load) throttle_tenths <= throttle_tenths_next;
      if (in_ready) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) pot_value <= div10(throttle_tenths_next);
  end

  a_tenths_bounded: assert property (@(posedge clk) disable iff (rst)
    throttle_tenths <= MAX_TENTHS)
    else $error("held throttle above full scale");

  a_state_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(throttle_tenths))
    else $error("held throttle moved without an update");

  a_kill_zeroes: assert property (@(posedge clk) disable iff (rst)
    (load && in_item.kill) |=> (throttle_tenths == '0) && (pot_value == 8'd0))
    else $error("brake or no pedaling did not zero the throttle");

  a_pot_matches: assert property (@(posedge clk) disable iff (rst)
    load |=> (({4'b0, pot_value} * 12'd10) <= throttle_tenths) &&
             (throttle_tenths < (({4'b0, pot_value} * 12'd10) + 12'd10)))
    else $error("pot value does not match held throttle");

endmodule

// ----- hw/rtl/throttle_ramp_limiter.sv -----
// Throttle ramp limiter for a pedal-assist drive. Feed one request per
// millisecond tick; every update_interval_ms ticks the block moves its held
// throttle (kept in tenths of a pot step) and emits one pot value, other
// ticks emit nothing. Brake or no pedaling drops the throttle to zero; else
// the throttle is lifted to an rpm-dependent floor, ramped by one step,
// clamped to the request and, below full-throttle level, capped by a line in
// wheel rpm up to RELEASE_RPM. A request is taken every clock cycle unless
// the pipeline stalls; a firing tick passes the input register and two cap
// stages, then the result register, on its way to m_tdata, and the held
// throttle itself is registered straight from its inputs so updates may
// follow back to back. Write configuration only while no update is in
// flight.
module throttle_ramp_limiter
  import trl_pkg::*;
#(
  parameter int RELEASE_RPM = 500
) (
  input  logic                 clk,
  input  logic                 rst,
  // Tick requests
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [7:0] throttle_request, [8] brake, [9] pedaling, [20:10] wheel_rpm,
  // [27:21] voltage_comp (signed), [31:28] zero
  input  logic [31:0]          s_tdata,
  // Pot values
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] pot_value
  output logic [7:0]           m_tdata,
  // Configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wr_data
);

  trl_cfg_t    cfg;
  trl_item_t   item;
  trl_capped_t capped;
  logic        capped_valid, capped_ready;
  logic        accept, fire, push;
  logic [9:0]  elapsed_ms, elapsed_ms_next;

  trl_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  // Tick counter: advance on every request, saturate rather than wrap, and
  // fire an update once the interval is reached (every tick for zero).
  assign accept          = s_tvalid && s_tready;
  assign elapsed_ms_next = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 10'd1 : elapsed_ms;
  assign fire            = elapsed_ms_next >= cfg.update_interval_ms;
  assign push            = s_tvalid && fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms <= '0;
    end else if (accept) begin
      elapsed_ms <= fire ? '0 : elapsed_ms_next;
    end
  end

  // Unpack the request; brake or no pedaling folds into one kill flag.
  assign item.request = s_tdata[7:0];
  assign item.kill    = s_tdata[8] || !s_tdata[9];
  assign item.rpm     = s_tdata[20:10];
  assign item.comp    = s_tdata[27:21];

  // Only firing ticks enter the pipeline; the rest just advance the counter.
  trl_cap_calc #(
    .RELEASE_RPM (RELEASE_RPM)
  ) u_cap_calc (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (push),
    .in_ready  (s_tready),
    .in_item   (item),
    .out_valid (capped_valid),
    .out_ready (capped_ready),
    .out_item  (capped)
  );

  // Hold the throttle state and the result register.
  trl_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (capped_valid),
    .in_ready  (capped_ready),
    .in_item   (capped),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pot_value (m_tdata)
  );

endmodule

// ----- sim/throttle_ramp_limiter_test.sv -----
`timescale 1ns / 1ps

module throttle_ramp_limiter_test
  import trl_pkg::*;
();

  localparam int PHASES         = 10;   // random phases, each with fresh registers
  localparam int PHASE_TICKS    = 60;
  localparam int PRESSURE_PHASE = 8;    // phase that runs the long output stall
  localparam int LONG_TICKS     = 1100; // enough for one update at interval 1023
  localparam int DRAIN_CYCLES   = 8;    // cap pipeline and result register are four deep, allow double
  localparam int RELEASE        = 500;  // matches the default RELEASE_RPM

  // One millisecond tick as the rider side sees it.
  typedef struct {
    logic [7:0]        request;
    logic              brake;
    logic              pedaling;
    logic [10:0]       rpm;
    logic signed [6:0] comp;
  } tick_t;

  // Directed table row: either a register write or a tick. A tick row may
  // carry a hand-computed pot value that replaces the predicted one.
  typedef struct {
    bit         is_cfg;
    trl_reg_t   idx;
    logic [9:0] value;
    tick_t      tick;
    bit         typed;
    logic [7:0] pot;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wr_data;

  // Mirror of the block: register file, tick counter and held throttle.
  trl_cfg_t   cfg;
  logic [9:0] elapsed_ms;
  logic [11:0] held_tenths;

  logic [7:0] pot_expected[$];  // pot values predicted, oldest first
  logic [7:0] pot_head;
  logic [7:0] ride_request;     // request the rider holds for a stretch
  row_t       dir_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int long_hold;                // output stall length, counted down by the sink
  int errors;
  int ticks_sent;
  int pots_checked;
  int settings_used;

  throttle_ramp_limiter i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Advance the mirror by one tick. Return 1 and the pot value when the
  // tick lands on an update; all math in plain ints, then truncate.
  function automatic bit step_throttle(input tick_t t, output logic [7:0] pot);
    int req;
    int held;
    int floor_t;
    int top;
    int off;
    int num;
    int cap;
    pot = '0;
    // Count up, hold at the top instead of wrapping.
    if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 10'd1;
    if (elapsed_ms < cfg.update_interval_ms) return 1'b0;
    elapsed_ms = '0;
    req  = int'(t.request);
    held = int'(held_tenths);
    // Brake or idle pedals: drop both the request and the held throttle.
    if (t.brake || !t.pedaling) begin
      req  = 0;
      held = 0;
    end
    // Lift to the speed floor, ramp one step, clamp to the request.
    floor_t = (int'(cfg.start_offset) + int'(t.rpm) / 10) * 10;
    if (held < floor_t) held = floor_t;
    held += int'(cfg.ramp_step_tenths);
    if (held > req * 10) held = req * 10;
    // Below full-throttle level, limit by the rpm line; a negative cap is zero.
    if (req < int'(cfg.full_throttle_level)) begin
      off = int'(cfg.start_offset);
      top = int'(cfg.base_cap) + int'(t.comp);
      if (top > int'(cfg.cap_ceiling)) top = int'(cfg.cap_ceiling);
      if (int'(t.rpm) > RELEASE) begin
        cap = (top < 0) ? 0 : top;
      end else begin
        num = off * RELEASE + (top - off) * int'(t.rpm);
        cap = (num <= 0) ? 0 : num / RELEASE;
      end
      if (held > cap * 10) held = cap * 10;
    end
    held_tenths = held[11:0];
    pot = 8'(held_tenths / 12'd10);
    return 1'b1;
  endfunction

  function automatic trl_cfg_t make_cfg(input logic [9:0] interval, input logic [6:0] ramp,
                                        input logic [6:0] offset, input logic [7:0] full,
                                        input logic [7:0] base, input logic [7:0] ceiling);
    trl_cfg_t c;
    c.update_interval_ms  = interval;
    c.ramp_step_tenths    = ramp;
    c.start_offset        = offset;
    c.full_throttle_level = full;
    c.base_cap            = base;
    c.cap_ceiling         = ceiling;
    return c;
  endfunction

  // Mostly short intervals so updates come often; the rest over full widths.
  function automatic trl_cfg_t random_cfg();
    logic [9:0] interval;
    logic [6:0] ramp;
    interval = ($urandom_range(9) == 0) ? 10'($urandom_range(40)) : 10'($urandom_range(4));
    ramp     = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 20));
    return make_cfg(interval, ramp, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Rider mostly pedals without braking and holds a request, so the ramp
  // gets to climb; speeds cluster around zero and the release rpm.
  function automatic tick_t random_tick();
    tick_t t;
    t.request  = ($urandom_range(3) != 0) ? ride_request : 8'($urandom);
    t.brake    = ($urandom_range(99) < 8);
    t.pedaling = ($urandom_range(99) >= 8);
    case ($urandom_range(3))
      0: t.rpm = 11'($urandom_range(60));
      1: t.rpm = 11'($urandom_range(520));
      2: t.rpm = 11'($urandom_range(480, 520));
      default: t.rpm = 11'($urandom);
    endcase
    t.comp = 7'($urandom);
    return t;
  endfunction

  function automatic row_t tick_row(input logic [7:0] request, input logic brake,
                                    input logic pedaling, input logic [10:0] rpm,
                                    input logic signed [6:0] comp, input bit typed,
                                    input logic [7:0] pot);
    row_t r;
    r.is_cfg        = 1'b0;
    r.idx           = REG_UPDATE_INTERVAL;
    r.value         = '0;
    r.tick.request  = request;
    r.tick.brake    = brake;
    r.tick.pedaling = pedaling;
    r.tick.rpm      = rpm;
    r.tick.comp     = comp;
    r.typed         = typed;
    r.pot           = pot;
    return r;
  endfunction

  function automatic row_t cfg_row(input trl_reg_t idx, input logic [9:0] value);
    row_t r;
    r = tick_row('0, 1'b0, 1'b0, '0, '0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    return r;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 28;
        recv_idle_pct = 62;
      end
      1: begin
        send_idle_pct = 62;
        recv_idle_pct = 28;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offer one request, idling at random first; predict once it is taken.
  task automatic push_tick(input tick_t t, input bit typed, input logic [7:0] typed_pot);
    logic [7:0] pot;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, t.comp, t.rpm, t.pedaling, t.brake, t.request};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
    if (step_throttle(t, pot)) pot_expected.push_back(typed ? typed_pot : pot);
  endtask

  // Drop valid, wait until every predicted pot value is out, then let the
  // pipeline run dry for ticks that fired nothing.
  task automatic settle(input int extra);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pot_expected.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write one register: enable for a single edge, mirror the masked value.
  task automatic write_reg(input trl_reg_t idx, input logic [9:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    case (idx)
      REG_UPDATE_INTERVAL: cfg.update_interval_ms  = value;
      REG_RAMP_STEP:       cfg.ramp_step_tenths    = value[6:0];
      REG_START_OFFSET:    cfg.start_offset        = value[6:0];
      REG_FULL_LEVEL:      cfg.full_throttle_level = value[7:0];
      REG_BASE_CAP:        cfg.base_cap            = value[7:0];
      REG_CAP_CEILING:     cfg.cap_ceiling         = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_cfg(input trl_cfg_t c);
    write_reg(REG_UPDATE_INTERVAL, c.update_interval_ms);
    write_reg(REG_RAMP_STEP, {3'b0, c.ramp_step_tenths});
    write_reg(REG_START_OFFSET, {3'b0, c.start_offset});
    write_reg(REG_FULL_LEVEL, {2'b0, c.full_throttle_level});
    write_reg(REG_BASE_CAP, {2'b0, c.base_cap});
    write_reg(REG_CAP_CEILING, {2'b0, c.cap_ceiling});
    settings_used++;
  endtask

  // Sink: hold off for a counted stretch when asked, else stall at random.
  always @(negedge clk) begin
    if (long_hold > 0) begin
      m_tready <= 1'b0;
      long_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every pot value taken against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pot_expected.size() == 0) begin
        $display("%0t: pot_value %0d arrived with nothing expected", $time, m_tdata);
        errors++;
      end else begin
        pot_head = pot_expected.pop_front();
        pots_checked++;
        if (m_tdata !== pot_head) begin
          $display("%0t: pot_value mismatch: expected %0d, actual %0d",
                   $time, pot_head, m_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    int ph;
    int i;
    trl_cfg_t c;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wr_data   = '0;
    long_hold     = 0;
    errors        = 0;
    ticks_sent    = 0;
    pots_checked  = 0;
    settings_used = 0;
    ride_request  = 8'd200;
    set_idling(0);
    cfg = make_cfg(RST_INTERVAL, RST_RAMP_STEP, RST_START_OFF, RST_FULL_LEVEL,
                   RST_BASE_CAP, RST_CAP_CEILING);
    elapsed_ms  = '0;
    held_tenths = '0;

    // Directed table. Update on every tick, reset values elsewhere at first.
    dir_rows.push_back(cfg_row(REG_UPDATE_INTERVAL, 10'd0));
    // brake, then idle pedals: zero regardless of request and speed
    dir_rows.push_back(tick_row(8'd255, 1'b1, 1'b1, 11'd0, 7'sd0, 1'b1, 8'd0));
    dir_rows.push_back(tick_row(8'd255, 1'b0, 1'b0, 11'd2047, 7'sd0, 1'b1, 8'd0));
    // top speed, full request: jump to the floor, then creep one step
    dir_rows.push_back(tick_row(8'd255, 1'b0, 1'b1, 11'd2047, 7'sd0, 1'b1, 8'd224));
    dir_rows.push_back(tick_row(8'd255, 1'b0, 1'b1, 11'd2047, 7'sd0, 1'b1, 8'd224));
    dir_rows.push_back(tick_row(8'd0, 1'b0, 1'b1, 11'd0, 7'sd0, 1'b1, 8'd0));
    // above release rpm: cap hits the ceiling, then drops with negative comp
    dir_rows.push_back(tick_row(8'd94, 1'b0, 1'b1, 11'd600, 7'sd40, 1'b1, 8'd80));
    dir_rows.push_back(tick_row(8'd94, 1'b0, 1'b1, 11'd600, -7'sd64, 1'b1, 8'd16));
    dir_rows.push_back(tick_row(8'd10, 1'b0, 1'b1, 11'd0, 7'sd0, 1'b1, 8'd10));
    // request right at full-throttle level skips the cap
    dir_rows.push_back(tick_row(8'd95, 1'b0, 1'b1, 11'd500, 7'sd0, 1'b1, 8'd70));
    dir_rows.push_back(tick_row(8'd94, 1'b0, 1'b1, 11'd500, 7'sd0, 1'b0, 8'd0));
    dir_rows.push_back(tick_row(8'd200, 1'b0, 1'b1, 11'd250, 7'sd0, 1'b0, 8'd0));
    dir_rows.push_back(tick_row(8'd255, 1'b0, 1'b1, 11'd1, -7'sd1, 1'b0, 8'd0));
    // negative cap, above and below release rpm
    dir_rows.push_back(cfg_row(REG_BASE_CAP, 10'd0));
    dir_rows.push_back(tick_row(8'd50, 1'b0, 1'b1, 11'd700, -7'sd64, 1'b1, 8'd0));
    dir_rows.push_back(tick_row(8'd50, 1'b0, 1'b1, 11'd400, -7'sd64, 1'b1, 8'd0));
    dir_rows.push_back(tick_row(8'd50, 1'b0, 1'b1, 11'd0, -7'sd64, 1'b0, 8'd0));
    // largest ramp, offset and base cap; the floor overshoots and the request clamps it
    dir_rows.push_back(cfg_row(REG_RAMP_STEP, 10'd127));
    dir_rows.push_back(cfg_row(REG_START_OFFSET, 10'd127));
    dir_rows.push_back(cfg_row(REG_FULL_LEVEL, 10'd0));
    dir_rows.push_back(cfg_row(REG_BASE_CAP, 10'd255));
    dir_rows.push_back(cfg_row(REG_CAP_CEILING, 10'd0));
    dir_rows.push_back(tick_row(8'd255, 1'b0, 1'b1, 11'd2047, 7'sd63, 1'b1, 8'd255));
    dir_rows.push_back(tick_row(8'd255, 1'b0, 1'b1, 11'd0, -7'sd64, 1'b0, 8'd0));
    dir_rows.push_back(cfg_row(REG_FULL_LEVEL, 10'd255));
    dir_rows.push_back(tick_row(8'd254, 1'b0, 1'b1, 11'd100, 7'sd63, 1'b0, 8'd0));
    dir_rows.push_back(cfg_row(REG_CAP_CEILING, 10'd255));
    dir_rows.push_back(tick_row(8'd254, 1'b0, 1'b1, 11'd2047, 7'sd63, 1'b0, 8'd0));
    dir_rows.push_back(tick_row(8'd0, 1'b1, 1'b0, 11'd2047, 7'sd63, 1'b1, 8'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the table; drain before every register write.
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        settle(DRAIN_CYCLES);
        write_reg(dir_rows[k].idx, dir_rows[k].value);
      end else begin
        push_tick(dir_rows[k].tick, dir_rows[k].typed, dir_rows[k].pot);
      end
    end

    // Random phases: reset values, low extremes, high extremes, then random.
    // Idling goes receiver-heavy, sender-heavy, then none.
    for (ph = 0; ph < PHASES; ph++) begin
      set_idling(ph * 3 / PHASES);
      case (ph)
        0: c = make_cfg(RST_INTERVAL, RST_RAMP_STEP, RST_START_OFF, RST_FULL_LEVEL,
                        RST_BASE_CAP, RST_CAP_CEILING);
        1: c = make_cfg(10'd0, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        2: c = make_cfg(10'd1, 7'd127, 7'd127, 8'd255, 8'd255, 8'd255);
        default: c = random_cfg();
      endcase
      // update on every tick so a stalled sink backs up into the input
      if (ph == PRESSURE_PHASE) c.update_interval_ms = '0;
      settle(DRAIN_CYCLES);
      apply_cfg(c);
      for (i = 0; i < PHASE_TICKS; i++) begin
        if (i % 25 == 0) ride_request = 8'($urandom);
        if (ph == PRESSURE_PHASE && i == 20) long_hold = 300;
        // pause the sender until the block has handed everything out
        if ((ph == PRESSURE_PHASE && i == 50) || $urandom_range(199) == 0) settle(0);
        push_tick(random_tick(), 1'b0, '0);
      end
    end

    // Longest interval: updates are rare, so run a long stretch of ticks.
    set_idling(2);
    c = random_cfg();
    c.update_interval_ms = 10'd1023;
    settle(DRAIN_CYCLES);
    apply_cfg(c);
    for (i = 0; i < LONG_TICKS; i++) begin
      if (i % 25 == 0) ride_request = 8'($urandom);
      push_tick(random_tick(), 1'b0, '0);
    end

    settle(DRAIN_CYCLES);
    repeat (10) @(posedge clk);
    $display("summary: %0d ticks sent, %0d pot values checked, %0d register sets",
             ticks_sent, pots_checked, settings_used);
    $display("summary: intervals 0 to 1023, brake and idle pedals, negative caps, stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("timeout: %0d pot values still outstanding", pot_expected.size());
    $display("tb: failure");
    $finish;
  end

endmodule
